@@ sv/lusf_pkg.sv @@
// ----------------------------------------------------------------------------
// lusf_pkg: shared types and constants for the uniform square finder
// Fixed field widths and the neighbor character group.
// ----------------------------------------------------------------------------
package lusf_pkg;

  localparam int CHAR_W     = 8;
  localparam int CFG_W      = 11;
  localparam int OUT_SIZE_W = 11;
  localparam int POS_W      = 10;

  typedef logic [CHAR_W-1:0] char_t;

  // characters of one cell and its three neighbors
  typedef struct packed {
    char_t cur;
    char_t left;
    char_t up;
    char_t upleft;
  } nbr_chars_t;

endpackage

@@ sv/lusf_line_buf.sv @@
// ----------------------------------------------------------------------------
// lusf_line_buf: line buffer for the row above
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lusf_line_buf #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 19
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/lusf_score.sv @@
// ----------------------------------------------------------------------------
// lusf_score: cell score
// One plus the least neighbor score when all four characters match and the cell is not on an edge, else one.
// ----------------------------------------------------------------------------
module lusf_score
  import lusf_pkg::*;
#(
  parameter int SW = 11
) (
  input  nbr_chars_t    chars,
  input  logic          edge_cell,
  input  logic [SW-1:0] left_size,
  input  logic [SW-1:0] up_size,
  input  logic [SW-1:0] upleft_size,
  output logic [SW-1:0] score
);

  logic          all_match;
  logic [SW-1:0] min_a;
  logic [SW-1:0] min_b;

  // character match across the 2x2 window
  assign all_match = (chars.cur == chars.left) && (chars.cur == chars.up) &&
                     (chars.cur == chars.upleft);

  // three-way minimum
  assign min_a = (up_size < left_size) ? up_size : left_size;
  assign min_b = (upleft_size < min_a) ? upleft_size : min_a;

  assign score = (!edge_cell && all_match) ? (min_b + SW'(1)) : SW'(1);

endmodule

@@ sv/largest_uniform_square_finder.sv @@
// ----------------------------------------------------------------------------
// largest_uniform_square_finder: largest single-character square in a grid
// Scans cells in raster order and reports the first largest uniform square.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake            payload
//  in_       input      in_valid/in_stall    in_cell_char
//  out_      output     out_valid/out_stall  out_square_size, out_bottom_row,
//                                            out_right_col
//  cfg_      input      cfg_valid/cfg_ready  cfg_grid_size
//
//  One cell is taken every cycle unless the input is stalled. A cell waits in
//  the input stage for the registered line buffer read of the row above, then
//  is scored and written back; the result for a grid goes from the input stage
//  register to the output register once its last cell is scored. Reset has no
//  clearing pass: first-row cells read entries not yet written for the current
//  grid, but they are edge cells and score one. A stalled result holds the
//  score stage when it carries a last cell, which then stalls the input.
//
module largest_uniform_square_finder
  import lusf_pkg::*;
#(
  parameter int MAX_SIZE = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CHAR_W-1:0]     in_cell_char,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_SIZE_W-1:0] out_square_size,
  output logic [POS_W-1:0]      out_bottom_row,
  output logic [POS_W-1:0]      out_right_col,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_grid_size
);

  localparam int CW       = $clog2(MAX_SIZE);
  localparam int SW       = $clog2(MAX_SIZE + 1);
  localparam int DW       = CHAR_W + SW;
  localparam int RST_SIDE = (MAX_SIZE < 1024) ? MAX_SIZE : 1024;

  // handshakes
  logic in_accept;
  logic cfg_write;
  logic s1_adv;

  // grid side and scan position
  logic [SW-1:0] side_r, side_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic          last_col, last_row;

  // score stage
  logic          s1_valid_r;
  char_t         s1_char_r;
  logic [CW-1:0] s1_col_r;
  logic [CW-1:0] s1_row_r;
  logic          s1_last_r;
  logic [DW-1:0] up_word;
  char_t         up_char;
  logic [SW-1:0] up_size;
  nbr_chars_t    chars;
  logic          edge_cell;
  logic [SW-1:0] score;
  logic          new_best;

  // neighbor and best state
  char_t         left_char_r;
  logic [SW-1:0] left_size_r;
  char_t         upleft_char_r;
  logic [SW-1:0] upleft_size_r;
  logic [SW-1:0] best_size_r;
  logic [CW-1:0] best_row_r;
  logic [CW-1:0] best_col_r;

  // result register
  logic                  out_valid_r;
  logic [OUT_SIZE_W-1:0] out_size_r;
  logic [POS_W-1:0]      out_row_r;
  logic [POS_W-1:0]      out_col_r;

  // handshake logic
  assign s1_adv    = s1_valid_r && (!s1_last_r || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = !s1_valid_r;
  assign cfg_write = cfg_valid && cfg_ready;

  // side length clamped to one through MAX_SIZE
  always_comb begin
    if (int'(cfg_grid_size) > MAX_SIZE) begin
      side_nxt = SW'(MAX_SIZE);
    end else if (cfg_grid_size == '0) begin
      side_nxt = SW'(1);
    end else begin
      side_nxt = SW'(cfg_grid_size);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SW'(RST_SIDE);
    end else if (cfg_write) begin
      side_r <= side_nxt;
    end
  end

  // scan position of the next cell
  assign last_col = (({1'b0, col_r} + 1'b1) >= (CW + 1)'(side_r));
  assign last_row = (({1'b0, row_r} + 1'b1) >= (CW + 1)'(side_r));

  always_comb begin
    col_nxt = col_r + 1'b1;
    row_nxt = row_r;
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : (row_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_write) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // input stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_char_r <= in_cell_char;
      s1_col_r  <= col_r;
      s1_row_r  <= row_r;
      s1_last_r <= last_col && last_row;
    end
  end

  // row above: characters and scores
  lusf_line_buf #(
    .DEPTH (MAX_SIZE),
    .AW    (CW),
    .DW    (DW)
  ) u_line_buf (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col_r),
    .wdata ({s1_char_r, score}),
    .re    (in_accept),
    .raddr (col_r),
    .rdata (up_word)
  );

  assign up_char = up_word[DW-1:SW];
  assign up_size = up_word[SW-1:0];

  // scoring of the cell in the input stage
  assign chars.cur    = s1_char_r;
  assign chars.left   = left_char_r;
  assign chars.up     = up_char;
  assign chars.upleft = (s1_col_r == '0) ? '0 : upleft_char_r;
  assign edge_cell    = (s1_row_r == '0) || (s1_col_r == '0);

  lusf_score #(
    .SW (SW)
  ) u_score (
    .chars       (chars),
    .edge_cell   (edge_cell),
    .left_size   (left_size_r),
    .up_size     (up_size),
    .upleft_size ((s1_col_r == '0) ? '0 : upleft_size_r),
    .score       (score)
  );

  assign new_best = !edge_cell && (score > best_size_r);

  // neighbor state follows each scored cell
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_write) begin
      left_char_r   <= '0;
      left_size_r   <= '0;
      upleft_char_r <= '0;
      upleft_size_r <= '0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        left_char_r   <= '0;
        left_size_r   <= '0;
        upleft_char_r <= '0;
        upleft_size_r <= '0;
      end else begin
        left_char_r   <= s1_char_r;
        left_size_r   <= score;
        upleft_char_r <= up_char;
        upleft_size_r <= up_size;
      end
    end
  end

  // best square so far, restarted after each grid
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_write) begin
      best_size_r <= SW'(1);
      best_row_r  <= '0;
      best_col_r  <= '0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        best_size_r <= SW'(1);
        best_row_r  <= '0;
        best_col_r  <= '0;
      end else if (new_best) begin
        best_size_r <= score;
        best_row_r  <= s1_row_r;
        best_col_r  <= s1_col_r;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      if (new_best) begin
        out_size_r <= OUT_SIZE_W'(score);
        out_row_r  <= POS_W'(s1_row_r);
        out_col_r  <= POS_W'(s1_col_r);
      end else begin
        out_size_r <= OUT_SIZE_W'(best_size_r);
        out_row_r  <= POS_W'(best_row_r);
        out_col_r  <= POS_W'(best_col_r);
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_square_size = out_size_r;
  assign out_bottom_row  = out_row_r;
  assign out_right_col   = out_col_r;

  // checks on the scan and pipeline control
  a_stall_needs_cell: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid_r))
    else $error("input stalled without a blocked last cell");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> out_valid_r)
    else $error("last cell of a grid gave no result");

  a_best_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    best_size_r != '0)
    else $error("best size dropped to zero");

  a_col_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    ((CW + 1)'(col_r) < (CW + 1)'(side_r)) && ((CW + 1)'(row_r) < (CW + 1)'(side_r)))
    else $error("scan position outside the grid");

endmodule
